### rtl/core/rpc_pkg.sv
package rpc_pkg;

  localparam int unsigned WidthW = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WidthW-1:0] width_t;
  typedef logic [1:0]        ring_status_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Request kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Latched ring kinds.
  localparam ring_status_t STATUS_NONE = 2'd0;
  localparam ring_status_t STATUS_SMS  = 2'd1;
  localparam ring_status_t STATUS_CALL = 2'd2;

  // Register indexes.
  localparam cfg_idx_t REG_SMS_MIN  = 3'd0;
  localparam cfg_idx_t REG_SMS_MAX  = 3'd1;
  localparam cfg_idx_t REG_CALL_MIN = 3'd2;
  localparam cfg_idx_t REG_CALL_MAX = 3'd3;
  localparam cfg_idx_t REG_HOLDOFF  = 3'd4;

  // Register reset values.
  localparam width_t SMS_MIN_RST  = 16'd11;
  localparam width_t SMS_MAX_RST  = 16'd17;
  localparam width_t CALL_MIN_RST = 16'd95;
  localparam width_t CALL_MAX_RST = 16'd105;
  localparam width_t HOLDOFF_RST  = 16'd660;

  localparam width_t WIDTH_MAX = 16'hFFFF;

  function automatic logic in_window(width_t w, width_t lo, width_t hi);
    return (lo < w) && (w < hi);
  endfunction

endpackage

### rtl/core/ring_pulse_classifier.sv
// A request accepted at a clock edge shows its result at the output on the next
// cycle, from the result register.
// Throughput: one request per cycle; in_ready stays high while the result register is
// empty or being emptied in the same cycle.
// Reset (synchronous, active low): registers go to their default windows, the pin is
// taken as idle high, low count, holdoff and ring latch clear, and no result is pending.
module ring_pulse_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic                        in_ring_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rpc_pkg::ring_status_t       out_ring_status,
  output logic                        out_pulse_classified,
  input  logic                        cfg_we,
  input  rpc_pkg::cfg_idx_t           cfg_index,
  input  rpc_pkg::width_t             cfg_wdata
);

  rpc_pkg::width_t sms_min_r, sms_max_r, call_min_r, call_max_r, holdoff_ms_r;

  logic                  last_level_r, last_level_nxt;
  rpc_pkg::width_t       low_ticks_r, low_ticks_nxt;
  rpc_pkg::width_t       holdoff_left_r, holdoff_left_nxt;
  rpc_pkg::ring_status_t latch_r, latch_nxt;

  logic                  out_valid_r;
  rpc_pkg::ring_status_t status_r, status_nxt;
  logic                  classified_r, classified_nxt;

  rpc_pkg::width_t       holdoff_dec;
  logic                  accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sms_min_r    <= rpc_pkg::SMS_MIN_RST;
      sms_max_r    <= rpc_pkg::SMS_MAX_RST;
      call_min_r   <= rpc_pkg::CALL_MIN_RST;
      call_max_r   <= rpc_pkg::CALL_MAX_RST;
      holdoff_ms_r <= rpc_pkg::HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rpc_pkg::REG_SMS_MIN:  sms_min_r    <= cfg_wdata;
        rpc_pkg::REG_SMS_MAX:  sms_max_r    <= cfg_wdata;
        rpc_pkg::REG_CALL_MIN: call_min_r   <= cfg_wdata;
        rpc_pkg::REG_CALL_MAX: call_max_r   <= cfg_wdata;
        rpc_pkg::REG_HOLDOFF:  holdoff_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_level_nxt   = last_level_r;
    low_ticks_nxt    = low_ticks_r;
    holdoff_left_nxt = holdoff_left_r;
    latch_nxt        = latch_r;
    status_nxt       = latch_r;
    classified_nxt   = 1'b0;
    holdoff_dec      = (holdoff_left_r != '0) ? holdoff_left_r - rpc_pkg::width_t'(1)
                                              : holdoff_left_r;

    if (in_kind == rpc_pkg::KIND_READ) begin
      // A read reports the latch as it was and then clears it.
      latch_nxt = rpc_pkg::STATUS_NONE;
    end else begin
      holdoff_left_nxt = holdoff_dec;
      last_level_nxt   = in_ring_level;
      if (!in_ring_level) begin
        if (last_level_r) begin
          low_ticks_nxt = rpc_pkg::width_t'(1);
        end else if (low_ticks_r != rpc_pkg::WIDTH_MAX) begin
          low_ticks_nxt = low_ticks_r + rpc_pkg::width_t'(1);
        end
      end else if (!last_level_r) begin
        if (holdoff_dec == '0) begin
          if (rpc_pkg::in_window(low_ticks_r, sms_min_r, sms_max_r)) begin
            latch_nxt      = rpc_pkg::STATUS_SMS;
            classified_nxt = 1'b1;
          end else if (rpc_pkg::in_window(low_ticks_r, call_min_r, call_max_r)) begin
            latch_nxt      = rpc_pkg::STATUS_CALL;
            classified_nxt = 1'b1;
          end
        end
        // Every rising edge restarts the holdoff, skipped or not.
        holdoff_left_nxt = holdoff_ms_r;
      end
      status_nxt = latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b1;
      low_ticks_r    <= '0;
      holdoff_left_r <= '0;
      latch_r        <= rpc_pkg::STATUS_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        last_level_r   <= last_level_nxt;
        low_ticks_r    <= low_ticks_nxt;
        holdoff_left_r <= holdoff_left_nxt;
        latch_r        <= latch_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      classified_r <= classified_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ring_status      = status_r;
  assign out_pulse_classified = classified_r;

  a_classified_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && classified_r) |-> (status_r != rpc_pkg::STATUS_NONE))
    else $error("classified result carries no ring kind");

  a_read_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == rpc_pkg::KIND_READ) |=> (latch_r == rpc_pkg::STATUS_NONE))
    else $error("ring latch not cleared by a read");

  a_rise_reloads_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == rpc_pkg::KIND_TICK && in_ring_level && !last_level_r)
      |=> (holdoff_left_r == $past(holdoff_ms_r)))
    else $error("holdoff not restarted on a rising edge");

  a_low_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !last_level_r |-> (low_ticks_r != '0))
    else $error("low count is zero while the pin is low");

endmodule
